// ===== src/bdsm_pkg.sv =====
package bdsm_pkg;

	// timestamp width default
	localparam int unsigned TIME_BITS_DEF = 48;

	// event codes
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_MREF  = 2'd1;
	localparam logic [1:0] OP_TORQ  = 2'd2;
	localparam logic [1:0] OP_SPARE = 2'd3;	// no action, outputs reported as they stand

	// register indexes
	localparam logic [1:0] REG_MAX_RPM = 2'd0;
	localparam logic [1:0] REG_INERTIA = 2'd1;
	localparam logic [1:0] REG_MGAIN   = 2'd2;
	localparam logic [1:0] REG_BGAIN   = 2'd3;

	localparam int unsigned CFG_W = 16;

	// register limits and reset values
	localparam logic [15:0] MAX_RPM_RST = 16'd6000;
	localparam logic [13:0] INERTIA_RST = 14'd1229;
	localparam logic [14:0] MGAIN_RST   = 15'd3277;
	localparam logic [14:0] BGAIN_RST   = 15'd2253;
	localparam logic [15:0] INERTIA_LO  = 16'd51;
	localparam logic [15:0] INERTIA_HI  = 16'd10240;
	localparam logic [15:0] GAIN_LO     = 16'd102;
	localparam logic [15:0] GAIN_HI     = 16'd20480;

	// shared unit widths
	localparam int unsigned MA_W   = 34;
	localparam int unsigned MB_W   = 27;
	localparam int unsigned PROD_W = MA_W + MB_W + 1;
	localparam int unsigned NUM_W  = 58;
	localparam int unsigned DIV_DW = 57;
	localparam int unsigned DIV_VW = 35;
	localparam int unsigned CNT_W  = 6;

	// model constants
	localparam logic [16:0]     DUTY_ONE     = 17'd65536;
	localparam logic [29:0]     PERIOD_RST   = 30'd1000000;
	localparam logic [31:0]     PERIOD_LIMIT = 32'd1000000000;
	localparam logic [31:0]     PULSE_LEN    = 32'd100000;
	localparam logic [17:0]     PHASE_MAX    = 18'd262143;
	localparam logic [MB_W-1:0] MGAIN_K      = MB_W'(100);
	localparam logic [MB_W-1:0] BRAKE_K      = MB_W'(450000);
	localparam logic [MB_W-1:0] DRAG_K       = MB_W'(18);
	localparam logic [MB_W-1:0] DEN_K        = MB_W'(1000000);

	// speed / 600000 = ((speed >> 6) * REV_RECIP) >> 40, exact for any 32-bit speed
	localparam logic [MB_W-1:0] REV_RECIP    = 27'd117281241;

	// divider run lengths
	localparam logic [CNT_W-1:0] ITER_SPEED = 6'd57;
	localparam logic [CNT_W-1:0] ITER_DUTY  = 6'd46;

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_EXEC = 9'b000000010,
		S_MUL  = 9'b000000100,
		S_DIVN = 9'b000001000,
		S_UPD  = 9'b000010000,
		S_PHS  = 9'b000100000,
		S_DIVD = 9'b001000000,
		S_DONE = 9'b010000000,
		S_SPD  = 9'b100000000
	} state_t;

	typedef struct packed {
		logic                    start;
		logic [DIV_DW-1:0]       dividend;
		logic [DIV_VW-1:0]       divisor;
		logic [CNT_W-1:0]        iters;
	} div_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [DIV_DW-1:0] quotient;
	} div_rsp_t;

endpackage

// ===== src/bdsm_if.sv =====
interface bdsm_in_if #(
	parameter int unsigned TIME_BITS = 48
);
	logic                 valid;
	logic                 ready;
	logic [1:0]           opcode;
	logic                 level;
	logic [TIME_BITS-1:0] now_ns;

	modport source (output valid, opcode, level, now_ns, input ready);
	modport sink   (input valid, opcode, level, now_ns, output ready);
endinterface

interface bdsm_out_if;
	logic        valid;
	logic        ready;
	logic        pulse;
	logic [15:0] speed_rpm;

	modport source (output valid, pulse, speed_rpm, input ready);
	modport sink   (input valid, pulse, speed_rpm, output ready);
endinterface

// ===== src/bdsm_mul.sv =====
module bdsm_mul
	import bdsm_pkg::*;
(
	input  logic                     clk,
	input  logic signed [MA_W-1:0]   a,
	input  logic        [MB_W-1:0]   b,
	output logic signed [PROD_W-1:0] prod_q
);

	// one signed by unsigned product a cycle, registered
	always_ff @(posedge clk) begin
		prod_q <= a * $signed({1'b0, b});
	end

endmodule

// ===== src/bdsm_div.sv =====
module bdsm_div
	import bdsm_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [DIV_DW-1:0] dvd_q;
	logic [DIV_DW-1:0] quo_q;
	logic [DIV_VW-1:0] rem_q;
	logic [DIV_VW-1:0] dvs_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIV_VW:0]   trial;
	logic              fits;

	// restoring step: one quotient bit a cycle, dividend taken MSB first
	assign trial = {rem_q, dvd_q[DIV_DW-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.iters;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DIV_DW-2:0], 1'b0};
			quo_q <= {quo_q[DIV_DW-2:0], fits};
			rem_q <= fits ? DIV_VW'(trial - {1'b0, dvs_q}) : trial[DIV_VW-1:0];
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

// ===== src/brake_disc_speed_model_core.sv =====
// Brake-disc speed model with two PWM duty captures. Each input item is one
// timestamped event (100 us tick, motor-reference edge or torque edge) and
// gives exactly one result item: the pulse level and the integer rpm. Items
// are handled one at a time by a small sequencer around one shared
// 34x27 multiplier and one shift-subtract divider (one quotient bit a
// cycle). A rising edge or an unused opcode goes straight from the decode
// step to the result, a falling edge may also run the divider for its duty,
// and a tick runs 9 multiply steps, the divider for the speed update and
// one reciprocal multiply for the phase advance. The next item can be
// accepted in the cycle after the result is raised; a result still waiting
// in the output register holds the sequencer in its last step.
module brake_disc_speed_model_core
	import bdsm_pkg::*;
#(
	parameter int unsigned TIME_BITS = TIME_BITS_DEF
)(
	input  logic               clk,
	input  logic               arst_n,
	bdsm_in_if.sink            in_ch,
	bdsm_out_if.source         out_ch,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_idx,
	input  logic [CFG_W-1:0]   cfg_data
);

	state_t state_q;

	// latched event
	logic [1:0]           op_q;
	logic                 lvl_q;
	logic [TIME_BITS-1:0] now_q;

	// configuration
	logic [15:0] max_rpm_q;
	logic [13:0] inertia_q;
	logic [14:0] mgain_q;
	logic [14:0] bgain_q;

	// plant state
	logic [1:0]           high_q;
	logic [TIME_BITS-1:0] last_q [2];
	logic [29:0]          per_q  [2];
	logic [16:0]          duty_q [2];
	logic [31:0]          spd_q;
	logic [17:0]          phase_q;
	logic                 pulse_q;
	logic [TIME_BITS-1:0] pend_q;

	// sequencer scratch
	logic [3:0]              step_q;
	logic [31:0]             tgt_q;
	logic signed [NUM_W-1:0] num_q;
	logic [34:0]             ns_q;

	// output register
	logic        out_valid_q;
	logic        out_pulse_q;
	logic [15:0] out_speed_q;

	logic                    ch;
	logic [TIME_BITS-1:0]    elapsed;
	logic                    rise_ok;
	logic                    fall_ok;
	logic                    ht_ge;
	logic [16:0]             dm;
	logic [16:0]             db;
	logic signed [MA_W-1:0]  mul_a;
	logic [MB_W-1:0]         mul_b;
	logic signed [PROD_W-1:0] prod;
	logic [NUM_W-1:0]        num_mag;
	logic [34:0]             ns_raw;
	logic [33:0]             lim;
	logic [18:0]             ph_sum;
	logic [17:0]             ph_sat;
	logic                    out_free;
	div_req_t                dreq;
	div_rsp_t                drsp;

	// channel selection and edge timing
	assign ch      = (op_q == OP_TORQ);
	assign elapsed = now_q - last_q[ch];
	assign rise_ok = (last_q[ch] != '0) && (elapsed != '0)
		&& (elapsed < TIME_BITS'(PERIOD_LIMIT));
	assign fall_ok = high_q[ch] && (last_q[ch] != '0) && (per_q[ch] != '0);
	assign ht_ge   = elapsed >= TIME_BITS'(per_q[ch]);

	// duty in use per channel
	assign dm = high_q[0] ? ((per_q[0] != '0) ? DUTY_ONE : '0) : duty_q[0];
	assign db = high_q[1] ? ((per_q[1] != '0) ? DUTY_ONE : '0) : duty_q[1];

	// multiplier operand schedule of a tick
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (step_q)
			4'd0: begin mul_a = MA_W'(dm);        mul_b = MB_W'(max_rpm_q); end
			4'd1: begin mul_a = MA_W'(mgain_q);   mul_b = MGAIN_K;          end
			4'd2: begin
				mul_a = $signed({2'b00, tgt_q}) - $signed({2'b00, spd_q});
				mul_b = prod[MB_W-1:0];
			end
			4'd3: begin mul_a = MA_W'(db);        mul_b = MB_W'(bgain_q);   end
			4'd4: begin mul_a = prod[MA_W-1:0];   mul_b = BRAKE_K;          end
			4'd5: begin mul_a = MA_W'(inertia_q); mul_b = DRAG_K;           end
			4'd6: begin mul_a = MA_W'(spd_q);     mul_b = prod[MB_W-1:0];   end
			4'd7: begin mul_a = MA_W'(inertia_q); mul_b = DEN_K;            end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
		// phase advance: speed / 64 times the reciprocal of 9375
		if (state_q == S_UPD) begin
			mul_a = MA_W'(spd_q[31:6]);
			mul_b = REV_RECIP;
		end
	end

	bdsm_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod)
	);

	assign num_mag = num_q[NUM_W-1] ? NUM_W'(-num_q) : NUM_W'(num_q);

	// divider requests
	always_comb begin
		dreq = '0;
		if (state_q == S_MUL && step_q == 4'd8) begin
			dreq.start    = 1'b1;
			dreq.dividend = num_mag[DIV_DW-1:0];
			dreq.divisor  = prod[DIV_VW-1:0];
			dreq.iters    = ITER_SPEED;
		end else if (state_q == S_EXEC && (op_q == OP_MREF || op_q == OP_TORQ)
				&& !lvl_q && fall_ok && !ht_ge) begin
			dreq.start    = 1'b1;
			dreq.dividend = {elapsed[29:0], 16'd0, 11'd0};
			dreq.divisor  = DIV_VW'(per_q[ch]);
			dreq.iters    = ITER_DUTY;
		end
	end

	bdsm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	// speed update and limit
	assign ns_raw = num_q[NUM_W-1] ? ({3'b000, spd_q} - {2'b00, drsp.quotient[32:0]})
		: ({3'b000, spd_q} + {2'b00, drsp.quotient[32:0]});
	assign lim    = {2'b00, max_rpm_q, 16'd0};

	// phase advance with saturation, whole quotient sits in bits 52..40
	assign ph_sum = {1'b0, phase_q} + {6'd0, prod[52:40]};
	assign ph_sat = ph_sum[18] ? PHASE_MAX : ph_sum[17:0];

	assign out_free = !out_valid_q || out_ch.ready;

	// configuration writes, inertia and gains saturated to their limits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_rpm_q <= MAX_RPM_RST;
			inertia_q <= INERTIA_RST;
			mgain_q   <= MGAIN_RST;
			bgain_q   <= BGAIN_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_MAX_RPM: max_rpm_q <= cfg_data;
				REG_INERTIA: inertia_q <= (cfg_data < INERTIA_LO) ? 14'(INERTIA_LO)
					: (cfg_data > INERTIA_HI) ? 14'(INERTIA_HI) : cfg_data[13:0];
				REG_MGAIN: mgain_q <= (cfg_data < GAIN_LO) ? 15'(GAIN_LO)
					: (cfg_data > GAIN_HI) ? 15'(GAIN_HI) : cfg_data[14:0];
				REG_BGAIN: bgain_q <= (cfg_data < GAIN_LO) ? 15'(GAIN_LO)
					: (cfg_data > GAIN_HI) ? 15'(GAIN_HI) : cfg_data[14:0];
				default: ;
			endcase
		end
	end

	// output valid: raised by the last step, dropped once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// sequencer and plant state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			high_q      <= '0;
			last_q[0]   <= '0;
			last_q[1]   <= '0;
			per_q[0]    <= PERIOD_RST;
			per_q[1]    <= PERIOD_RST;
			duty_q[0]   <= '0;
			duty_q[1]   <= '0;
			spd_q       <= '0;
			phase_q     <= '0;
			pulse_q     <= 1'b0;
			pend_q      <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_ch.valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (op_q == OP_TICK) begin
						step_q  <= '0;
						state_q <= S_MUL;
					end else if (op_q == OP_MREF || op_q == OP_TORQ) begin
						if (lvl_q) begin
							if (rise_ok) begin
								per_q[ch] <= elapsed[29:0];
							end
							last_q[ch] <= now_q;
							high_q[ch] <= 1'b1;
							state_q    <= S_DONE;
						end else begin
							high_q[ch] <= 1'b0;
							if (!fall_ok) begin
								duty_q[ch] <= '0;
								state_q    <= S_DONE;
							end else if (ht_ge) begin
								duty_q[ch] <= DUTY_ONE;
								state_q    <= S_DONE;
							end else begin
								state_q <= S_DIVD;
							end
						end
					end else begin
						state_q <= S_DONE;
					end
				end
				S_MUL: begin
					step_q <= step_q + 1'b1;
					if (step_q == 4'd8) begin
						state_q <= S_DIVN;
					end
				end
				S_DIVN: begin
					if (drsp.done) begin
						state_q <= S_SPD;
					end
				end
				S_SPD: begin
					if (ns_q[34]) begin
						spd_q <= '0;
					end else if (ns_q[33:0] > lim) begin
						spd_q <= lim[31:0];
					end else begin
						spd_q <= ns_q[31:0];
					end
					state_q <= S_UPD;
				end
				S_UPD: begin
					if (pulse_q && now_q >= pend_q) begin
						pulse_q <= 1'b0;
					end
					state_q <= S_PHS;
				end
				S_PHS: begin
					if (!pulse_q && ph_sat[17:16] != 2'b00) begin
						phase_q <= {2'b00, ph_sat[15:0]};
						pulse_q <= 1'b1;
						pend_q  <= now_q + TIME_BITS'(PULSE_LEN);
					end else begin
						phase_q <= ph_sat;
					end
					state_q <= S_DONE;
				end
				S_DIVD: begin
					if (drsp.done) begin
						duty_q[ch] <= drsp.quotient[16:0];
						state_q    <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath scratch and event latch
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_ch.valid) begin
			op_q  <= in_ch.opcode;
			lvl_q <= in_ch.level;
			now_q <= in_ch.now_ns;
		end
		if (state_q == S_MUL) begin
			case (step_q)
				4'd1: tgt_q <= prod[31:0];
				4'd3: num_q <= NUM_W'(prod);
				4'd5: num_q <= num_q - NUM_W'(prod);
				4'd7: num_q <= num_q - NUM_W'(prod);
				default: ;
			endcase
		end
		if (state_q == S_DIVN && drsp.done) begin
			ns_q <= ns_raw;
		end
		if (state_q == S_DONE && out_free) begin
			out_pulse_q <= pulse_q;
			out_speed_q <= spd_q[31:16];
		end
	end

	assign in_ch.ready      = (state_q == S_IDLE);
	assign out_ch.valid     = out_valid_q;
	assign out_ch.pulse     = out_pulse_q;
	assign out_ch.speed_rpm = out_speed_q;

endmodule

// ===== src/bdsm_chk.sv =====
module bdsm_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] out_speed
);

	// a result waiting is not dropped
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// a waiting result keeps its speed value
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_speed))
		else $error("result changed while stalled");

	// one item at a time: busy after acceptance
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item accepted while busy");

	// a new result appears only as the sequencer returns to idle
	a_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("result raised while item in work");

endmodule

bind brake_disc_speed_model_core bdsm_chk u_bdsm_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_speed (out_ch.speed_rpm)
);

// ===== tb/brake_disc_speed_model_core_tb.sv =====
`timescale 1ns / 1ps

module brake_disc_speed_model_core_tb;
	import bdsm_pkg::*;

	localparam int unsigned TB = TIME_BITS_DEF;
	localparam logic [TB-1:0] TMAX = {TB{1'b1}};
	localparam int unsigned CYCLE_LIMIT = 3000000;
	localparam int unsigned SETTLE = 150;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_idx;
	logic [CFG_W-1:0] cfg_data;

	bdsm_in_if #(.TIME_BITS(TB)) in_ch ();
	bdsm_out_if out_ch ();

	brake_disc_speed_model_core #(.TIME_BITS(TB)) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.out_ch   (out_ch),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	typedef struct packed {
		logic        pulse;
		logic [15:0] speed_rpm;
	} disc_out_t;

	// shadow copy of the disc model
	int unsigned       m_max_rpm, m_inertia, m_mgain, m_bgain;
	logic              ch_high [2];
	logic [TB-1:0]     ch_rise [2];
	longint unsigned   ch_period [2];
	longint unsigned   ch_duty [2];
	longint unsigned   speed_q16;
	int unsigned       phase_q16;
	logic              pulse_lvl;
	logic [TB-1:0]     pulse_end;

	disc_out_t         pending_outs [$];
	int unsigned       mismatches;
	int unsigned       cycles;
	int unsigned       snd_idle_pct;
	int unsigned       rcv_stall_pct;
	logic [TB-1:0]     t_now;
	logic              lvl_seen [2];

	// clock
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// receiver back-pressure
	always @(negedge clk) begin
		out_ch.ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
	end

	// result checker
	always @(posedge clk) begin
		disc_out_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_outs.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected item: pulse %0d rpm %0d",
						out_ch.pulse, out_ch.speed_rpm);
			end else begin
				want = pending_outs.pop_front();
				if (want.pulse !== out_ch.pulse || want.speed_rpm !== out_ch.speed_rpm) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp pulse %0d rpm %0d, got pulse %0d rpm %0d",
							want.pulse, want.speed_rpm, out_ch.pulse, out_ch.speed_rpm);
				end
			end
		end
	end

	function automatic int unsigned clamp_cfg(int unsigned v, int unsigned lo, int unsigned hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic longint duty_in_use(int ch);
		if (ch_high[ch])
			return (ch_period[ch] > 0) ? 65536 : 0;
		return (ch_duty[ch] > 65536) ? 65536 : longint'(ch_duty[ch]);
	endfunction

	// PWM capture of one channel
	task automatic edge_update(int ch, logic lvl, logic [TB-1:0] t);
		logic [TB-1:0] dt;
		dt = t - ch_rise[ch];
		if (lvl) begin
			if (ch_rise[ch] != 0 && dt > 0 && dt < 64'd1000000000)
				ch_period[ch] = 64'(dt);
			ch_rise[ch] = t;
			ch_high[ch] = 1'b1;
		end else begin
			if (ch_high[ch] && ch_rise[ch] != 0 && ch_period[ch] > 0) begin
				if (dt >= ch_period[ch])
					ch_duty[ch] = 65536;
				else
					ch_duty[ch] = ({16'd0, dt} << 16) / ch_period[ch];
			end else begin
				ch_duty[ch] = 0;
			end
			ch_high[ch] = 1'b0;
		end
	endtask

	// speed integration and revolution pulse
	task automatic tick_update(logic [TB-1:0] t);
		longint dm, db, spd, num, den, lim, nxt;
		longint unsigned ph;
		dm = duty_in_use(0);
		db = duty_in_use(1);
		spd = longint'(speed_q16);
		num = (dm * longint'(m_max_rpm) - spd) * longint'(m_mgain) * 100
			- db * longint'(m_bgain) * 450000
			- spd * 18 * longint'(m_inertia);
		den = longint'(m_inertia) * 1000000;
		lim = longint'(m_max_rpm) * 65536;
		nxt = spd + num / den;
		if (nxt < 0)
			nxt = 0;
		if (nxt > lim)
			nxt = lim;
		speed_q16 = nxt;
		if (pulse_lvl && t >= pulse_end)
			pulse_lvl = 1'b0;
		ph = phase_q16 + speed_q16 / 600000;
		if (ph > 262143)
			ph = 262143;
		phase_q16 = 32'(ph);
		if (!pulse_lvl && phase_q16 >= 65536) begin
			phase_q16 = phase_q16 & 32'hFFFF;
			pulse_lvl = 1'b1;
			pulse_end = t + TB'(100000);
		end
	endtask

	task automatic predict_event(logic [1:0] op, logic lvl, logic [TB-1:0] t);
		disc_out_t r;
		case (op)
			OP_TICK: tick_update(t);
			OP_MREF: edge_update(0, lvl, t);
			OP_TORQ: edge_update(1, lvl, t);
			default: ;
		endcase
		r.pulse = pulse_lvl;
		r.speed_rpm = speed_q16[31:16];
		pending_outs.push_back(r);
	endtask

	// one event item, entered and left at a falling edge
	task automatic send_event(logic [1:0] op, logic lvl, logic [TB-1:0] t);
		if ($urandom_range(0, 99) < snd_idle_pct) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.opcode <= op;
		in_ch.level <= lvl;
		in_ch.now_ns <= t;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		predict_event(op, lvl, t);
		@(negedge clk);
	endtask

	// drain, let the block settle, then write all four registers
	task automatic write_regs(int unsigned mr, int unsigned ine, int unsigned mg, int unsigned bg);
		in_ch.valid <= 1'b0;
		@(negedge clk);
		while (pending_outs.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_idx <= 2'(i);
			cfg_data <= (i == REG_MAX_RPM) ? mr[15:0] : (i == REG_INERTIA) ? ine[15:0] :
				(i == REG_MGAIN) ? mg[15:0] : bg[15:0];
			@(negedge clk);
		end
		cfg_we <= 1'b0;
		m_max_rpm = clamp_cfg(mr & 16'hFFFF, 0, 65535);
		m_inertia = clamp_cfg(ine & 16'hFFFF, INERTIA_LO, INERTIA_HI);
		m_mgain = clamp_cfg(mg & 16'hFFFF, GAIN_LO, GAIN_HI);
		m_bgain = clamp_cfg(bg & 16'hFFFF, GAIN_LO, GAIN_HI);
	endtask

	// edges before any rise, rise at zero, long periods, unused code
	task automatic test_edge_cases();
		send_event(OP_MREF, 1'b0, 48'd5);
		send_event(OP_MREF, 1'b1, 48'd0);
		send_event(OP_MREF, 1'b0, 48'd300);
		send_event(OP_TORQ, 1'b1, 48'd1000);
		send_event(OP_TORQ, 1'b1, 48'd1000);
		send_event(OP_TORQ, 1'b1, 48'd1500000000);
		send_event(OP_TORQ, 1'b0, 48'd1500600000);
		send_event(OP_SPARE, 1'b1, TMAX);
		send_event(OP_MREF, 1'b1, 48'd2000000);
		send_event(OP_MREF, 1'b0, 48'd2900000);
		send_event(OP_MREF, 1'b1, 48'd3000000);
		send_event(OP_MREF, 1'b0, 48'd3500000);
		send_event(OP_MREF, 1'b1, 48'd4000000);
		send_event(OP_TICK, 1'b1, TMAX);
		send_event(OP_TICK, 1'b0, 48'd0);
	endtask

	// duty at one, strong drive, wrapped time stamps
	task automatic test_full_drive();
		logic [TB-1:0] t;
		t = TMAX - 48'd5000000;
		send_event(OP_TORQ, 1'b0, t);
		for (int i = 0; i < 120; i++) begin
			t = t + 48'd100000;
			send_event(OP_TICK, 1'(i), t);
		end
		send_event(OP_MREF, 1'b0, t + 48'd20);
		send_event(OP_TORQ, 1'b1, t + 48'd40);
	endtask

	// mostly well-formed PWM streams with ticks, some noise
	task automatic test_random_events(int unsigned n);
		logic [1:0] op;
		logic lvl;
		int ch;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 99)) inside
				[0:1]: t_now = TB'({$urandom, $urandom});
				[2:3]: t_now = TB'(t_now + {$urandom_range(0, 3), $urandom});
				[4:5]: t_now = TMAX - $urandom_range(0, 300000);
				default: t_now = t_now + $urandom_range(1, 60000);
			endcase
			case ($urandom_range(0, 99)) inside
				[0:49]: op = OP_TICK;
				[50:73]: op = OP_MREF;
				[74:96]: op = OP_TORQ;
				default: op = OP_SPARE;
			endcase
			ch = (op == OP_TORQ) ? 1 : 0;
			if ($urandom_range(0, 9) == 0)
				lvl = 1'($urandom_range(0, 1));
			else
				lvl = !lvl_seen[ch];
			if (op == OP_MREF || op == OP_TORQ)
				lvl_seen[ch] = lvl;
			send_event(op, lvl, t_now);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		snd_idle_pct = 0;
		rcv_stall_pct = 0;
		in_ch.valid = 1'b0;
		in_ch.opcode = OP_TICK;
		in_ch.level = 1'b0;
		in_ch.now_ns = '0;
		cfg_we = 1'b0;
		cfg_idx = REG_MAX_RPM;
		cfg_data = '0;
		t_now = 48'd1000;
		lvl_seen[0] = 1'b0;
		lvl_seen[1] = 1'b0;
		m_max_rpm = MAX_RPM_RST;
		m_inertia = INERTIA_RST;
		m_mgain = MGAIN_RST;
		m_bgain = BGAIN_RST;
		for (int i = 0; i < 2; i++) begin
			ch_high[i] = 1'b0;
			ch_rise[i] = '0;
			ch_period[i] = 1000000;
			ch_duty[i] = 0;
		end
		speed_q16 = 0;
		phase_q16 = 0;
		pulse_lvl = 1'b0;
		pulse_end = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_edge_cases();
		write_regs(65535, 0, 65535, 0);
		test_full_drive();
		write_regs(0, 65535, 0, 65535);
		test_edge_cases();

		// four idling phases over several register settings
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
				1: begin snd_idle_pct = 65; rcv_stall_pct = 0;  end
				2: begin snd_idle_pct = 0;  rcv_stall_pct = 65; end
				default: begin snd_idle_pct = 8; rcv_stall_pct = 8; end
			endcase
			if (ph == 0)
				write_regs(6000, 51, 20480, 102);
			else if (ph == 4)
				write_regs(MAX_RPM_RST, INERTIA_RST, MGAIN_RST, BGAIN_RST);
			else
				write_regs($urandom_range(0, 65535), $urandom_range(0, 12000),
					$urandom_range(0, 24000), $urandom_range(0, 24000));
			test_random_events(200);
		end

		in_ch.valid <= 1'b0;
		while (pending_outs.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
		if (mismatches == 0 && pending_outs.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== brake_disc_speed_model_core.f =====
src/bdsm_pkg.sv
src/bdsm_if.sv
src/bdsm_mul.sv
src/bdsm_div.sv
src/brake_disc_speed_model_core.sv
src/bdsm_chk.sv
tb/brake_disc_speed_model_core_tb.sv
